@@ rtl/lfcp_pkg.sv @@
// lfcp_pkg: shared types, constants and color sample tables for the line follower
`timescale 1ns / 1ps

package lfcp_pkg;

    // color class codes
    localparam logic [2:0] COLOR_BLUE  = 3'd1;
    localparam logic [2:0] COLOR_BLACK = 3'd2;
    localparam logic [2:0] COLOR_GREEN = 3'd3;
    localparam logic [2:0] COLOR_RED   = 3'd5;
    localparam logic [2:0] COLOR_WHITE = 3'd7;

    // track readings for a white border seen from either side
    localparam logic [2:0] READ_BLUE_EDGE  = 3'd0;
    localparam logic [2:0] READ_GREEN_EDGE = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_GAIN_P = 2'd0;
    localparam logic [1:0] REG_GAIN_I = 2'd1;
    localparam logic [1:0] REG_GAIN_D = 2'd2;

    localparam logic [15:0] WHITE_LIMIT    = 16'd1200;
    localparam int          SAMPLE_COUNT   = 5;
    localparam logic [2:0]  LAST_SAMPLE    = 3'(SAMPLE_COUNT - 1);
    localparam logic [1:0]  LAST_CHANNEL   = 2'd2;
    localparam int          INT_WINDOW     = 25;
    localparam logic [15:0] FIXED_STEPS    = 16'd25;
    localparam logic [16:0] STEP_GAIN      = 17'd30;
    // ceil(2^21 / 3), exact truncating divide by three for values below 2^21
    localparam int          RECIP3_SHIFT   = 21;
    localparam logic [20:0] RECIP3         = 21'd699051;
    localparam int          ACC_W          = 42;

    // one operation of the shared multiply-accumulate unit
    typedef struct packed {
        logic               en;
        logic               clr;
        logic               shl;
        logic signed [16:0] a;
        logic signed [24:0] b;
    } mac_op_t;

    // red, green, blue of each fixed color sample
    function automatic logic [7:0] sample_level(input logic [2:0] idx, input logic [1:0] ch);
        logic [7:0] lvl;
        lvl = 8'd0;
        unique case (idx)
            3'd0:
            begin
                lvl = (ch == 2'd0) ? 8'd27 : (ch == 2'd1) ? 8'd46 : 8'd100;
            end
            3'd1:
            begin
                lvl = 8'd0;
            end
            3'd2:
            begin
                lvl = (ch == 2'd0) ? 8'd48 : (ch == 2'd1) ? 8'd104 : 8'd70;
            end
            3'd3:
            begin
                lvl = (ch == 2'd0) ? 8'd112 : (ch == 2'd1) ? 8'd11 : 8'd18;
            end
            default:
            begin
                lvl = 8'd255;
            end
        endcase
        return lvl;
    endfunction

    // class code of each fixed color sample
    function automatic logic [2:0] sample_class(input logic [2:0] idx);
        logic [2:0] cls;
        cls = COLOR_WHITE;
        unique case (idx)
            3'd0:    cls = COLOR_BLUE;
            3'd1:    cls = COLOR_BLACK;
            3'd2:    cls = COLOR_GREEN;
            3'd3:    cls = COLOR_RED;
            default: cls = COLOR_WHITE;
        endcase
        return cls;
    endfunction

endpackage

@@ rtl/lfcp_mac.sv @@
// lfcp_mac: shared signed multiply-accumulate unit
`timescale 1ns / 1ps

module lfcp_mac (
    input  logic                                  clk,
    input  lfcp_pkg::mac_op_t                     op,
    output logic signed [lfcp_pkg::ACC_W-1:0]     acc,
    output logic signed [lfcp_pkg::ACC_W-1:0]     sum
);
    import lfcp_pkg::*;

    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] shifted;
    logic signed [ACC_W-1:0] acc_reg;

    // product, optionally weighted by 2^10 for the upper partial product
    assign prod    = ACC_W'(op.a) * ACC_W'(op.b);
    assign shifted = op.shl ? (prod <<< 10) : prod;

    // accumulate or start fresh
    assign sum = (op.clr ? ACC_W'(0) : acc_reg) + shifted;
    assign acc = acc_reg;

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            acc_reg <= sum;
        end
    end

endmodule

@@ rtl/line_follow_color_pid.sv @@
// line_follow_color_pid: color classifier and PID steering sequencer, top level
`timescale 1ns / 1ps

// Each beat on s_* carries red, green, blue, a clear count and a heading; one
// result beat follows on m_* with the color class, the signed Q16.8 PID
// action and the two wheel step counts. All multiplications run through one
// multiply-accumulate unit under a sequencer: squared distances (five
// samples, three channels), then the track update, the integral product, its
// divide by three, the proportional and derivative terms, saturation and the
// step count, and last the load of the output register. s_tready stays low
// from the accepting edge until that load. A finished result waits in the
// output register while the next beat is taken; the sequencer only waits at
// its last step if that register is still full. Gains on cfg_* are to be
// written only while the block is idle; the block does not enforce this.
module line_follow_color_pid (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: red_level[7:0], green_level[15:8], blue_level[23:16],
    // clear_count[39:24], heading[41:40], zero fill to 48 bits
    input  logic [47:0] s_tdata,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: color_class[2:0], control_action[26:3], left_steps[42:27],
    // right_steps[58:43], zero fill to 64 bits
    output logic [63:0] m_tdata
);
    import lfcp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIST, ST_TRACK, ST_IMUL, ST_MAG, ST_DIVL, ST_DIVH,
        ST_ISUM, ST_PROP, ST_DERIV, ST_SAT, ST_STEP, ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]  samp_reg, samp_next;
    logic [1:0]  chan_reg, chan_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg, blue_next;
    logic [15:0] clear_reg, clear_next;
    logic [1:0]  heading_reg, heading_next;
    logic [2:0]  best_idx_reg, best_idx_next;
    logic [17:0] best_dist_reg, best_dist_next;
    logic [2:0]  color_reg, color_next;
    logic [2:0]  last_reg, last_next;
    logic signed [3:0] err_reg, err_next;
    logic signed [3:0] prev_reg, prev_next;
    logic signed [4:0] dprev_reg, dprev_next;
    logic signed [5:0] int_reg, int_next;
    logic        neg_reg, neg_next;
    logic [19:0] mag_reg, mag_next;
    logic signed [23:0] action_reg, action_next;
    logic signed [15:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  out_color_reg, out_color_next;
    logic [23:0] out_action_reg, out_action_next;
    logic [15:0] out_left_reg, out_left_next;
    logic [15:0] out_right_reg, out_right_next;

    mac_op_t                 mac_op;
    logic signed [ACC_W-1:0] mac_acc;
    logic signed [ACC_W-1:0] mac_sum;

    // working values
    logic [7:0]        chan_level;
    logic signed [8:0] diff;
    logic [2:0]        color_c;
    logic [2:0]        reading;
    logic signed [3:0] err_c;
    logic signed [7:0] window;
    logic [19:0]       quot;
    logic signed [24:0] itrm;
    logic signed [24:0] act_mag;
    logic [15:0]       big;
    logic              mirrored;

    lfcp_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .acc (mac_acc),
        .sum (mac_sum)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, out_right_reg, out_left_reg, out_action_reg, out_color_reg};

    // gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= 16'sd256;
            gain_i_reg <= 16'sd0;
            gain_d_reg <= 16'sd128;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GAIN_P: gain_p_reg <= cfg_wdata;
                REG_GAIN_I: gain_i_reg <= cfg_wdata;
                REG_GAIN_D: gain_d_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // channel under test and its difference to the sample
    always_comb
    begin
        unique case (chan_reg)
            2'd0:    chan_level = red_reg;
            2'd1:    chan_level = green_reg;
            default: chan_level = blue_reg;
        endcase
        diff = $signed({1'b0, chan_level}) - $signed({1'b0, sample_level(samp_reg, chan_reg)});
    end

    // color class, track reading and error
    always_comb
    begin
        color_c = (clear_reg > WHITE_LIMIT) ? COLOR_WHITE : sample_class(best_idx_reg);
        reading = color_c;
        if (color_c == COLOR_WHITE && last_reg > COLOR_BLACK)
        begin
            reading = READ_GREEN_EDGE;
        end
        else if (color_c == COLOR_WHITE && last_reg < COLOR_BLACK)
        begin
            reading = READ_BLUE_EDGE;
        end
        err_c = (reading == COLOR_RED) ? 4'sd0
              : 4'($signed({2'b00, COLOR_BLACK}) - $signed({2'b00, reading}));
        window = $signed({int_reg[5], int_reg, 1'b0}) + 8'(err_c);
    end

    // quotient of the integral divide, magnitudes and step count
    always_comb
    begin
        quot     = mac_acc[RECIP3_SHIFT+19:RECIP3_SHIFT];
        itrm     = neg_reg ? -$signed({5'd0, quot}) : $signed({5'd0, quot});
        act_mag  = action_reg[23] ? -25'(action_reg) : 25'(action_reg);
        big      = (|mac_acc[ACC_W-1:24]) ? 16'hFFFF : mac_acc[23:8];
        mirrored = heading_reg[0] ^ heading_reg[1];
    end

    // sequencer next state and multiply-accumulate operation
    always_comb
    begin
        state_next      = state_reg;
        samp_next       = samp_reg;
        chan_next       = chan_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        clear_next      = clear_reg;
        heading_next    = heading_reg;
        best_idx_next   = best_idx_reg;
        best_dist_next  = best_dist_reg;
        color_next      = color_reg;
        last_next       = last_reg;
        err_next        = err_reg;
        prev_next       = prev_reg;
        dprev_next      = dprev_reg;
        int_next        = int_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        action_next     = action_reg;
        m_valid_next    = m_valid_reg;
        out_color_next  = out_color_reg;
        out_action_next = out_action_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        mac_op          = '0;

        // result leaves on its handshake
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    red_next     = s_tdata[7:0];
                    green_next   = s_tdata[15:8];
                    blue_next    = s_tdata[23:16];
                    clear_next   = s_tdata[39:24];
                    heading_next = s_tdata[41:40];
                    samp_next    = 3'd0;
                    chan_next    = 2'd0;
                    state_next   = ST_DIST;
                end
            end
            ST_DIST:
            begin
                mac_op.en  = 1'b1;
                mac_op.clr = (chan_reg == 2'd0);
                mac_op.a   = 17'(diff);
                mac_op.b   = 25'(diff);
                if (chan_reg == LAST_CHANNEL)
                begin
                    // first sample wins ties
                    if (samp_reg == 3'd0 || mac_sum[17:0] < best_dist_reg)
                    begin
                        best_dist_next = mac_sum[17:0];
                        best_idx_next  = samp_reg;
                    end
                    chan_next = 2'd0;
                    if (samp_reg == LAST_SAMPLE)
                    begin
                        state_next = ST_TRACK;
                    end
                    else
                    begin
                        samp_next = samp_reg + 3'd1;
                    end
                end
                else
                begin
                    chan_next = chan_reg + 2'd1;
                end
            end
            ST_TRACK:
            begin
                color_next = color_c;
                err_next   = err_c;
                prev_next  = err_c;
                dprev_next = 5'(prev_reg) - 5'(err_c);
                if (reading != COLOR_RED)
                begin
                    last_next = reading;
                end
                if (window <= 8'sd25 && window >= -8'sd25)
                begin
                    int_next = int_reg + 6'(err_c);
                end
                state_next = ST_IMUL;
            end
            ST_IMUL:
            begin
                mac_op.en  = 1'b1;
                mac_op.clr = 1'b1;
                mac_op.a   = 17'(gain_i_reg);
                mac_op.b   = 25'(int_reg);
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                neg_next   = mac_acc[ACC_W-1];
                mag_next   = mac_acc[ACC_W-1] ? 20'(-mac_acc) : 20'(mac_acc);
                state_next = ST_DIVL;
            end
            ST_DIVL:
            begin
                // lower partial product of magnitude times reciprocal
                mac_op.en  = 1'b1;
                mac_op.clr = 1'b1;
                mac_op.a   = $signed({7'd0, mag_reg[9:0]});
                mac_op.b   = $signed({4'd0, RECIP3});
                state_next = ST_DIVH;
            end
            ST_DIVH:
            begin
                mac_op.en  = 1'b1;
                mac_op.shl = 1'b1;
                mac_op.a   = $signed({7'd0, mag_reg[19:10]});
                mac_op.b   = $signed({4'd0, RECIP3});
                state_next = ST_ISUM;
            end
            ST_ISUM:
            begin
                // integral term, truncated toward zero, starts the sum
                mac_op.en  = 1'b1;
                mac_op.clr = 1'b1;
                mac_op.a   = 17'sd1;
                mac_op.b   = itrm;
                state_next = ST_PROP;
            end
            ST_PROP:
            begin
                mac_op.en  = 1'b1;
                mac_op.a   = 17'(gain_p_reg);
                mac_op.b   = 25'(err_reg);
                state_next = ST_DERIV;
            end
            ST_DERIV:
            begin
                mac_op.en  = 1'b1;
                mac_op.a   = 17'(gain_d_reg);
                mac_op.b   = 25'(dprev_reg);
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                if (mac_acc > 42'sd8388607)
                begin
                    action_next = 24'sh7FFFFF;
                end
                else if (mac_acc < -42'sd8388608)
                begin
                    action_next = 24'sh800000;
                end
                else
                begin
                    action_next = mac_acc[23:0];
                end
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                mac_op.en  = 1'b1;
                mac_op.clr = 1'b1;
                mac_op.a   = STEP_GAIN;
                mac_op.b   = act_mag;
                state_next = ST_DONE;
            end
            default:
            begin
                // load the output register once it is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_color_next  = color_reg;
                    out_action_next = action_reg;
                    out_left_next   = FIXED_STEPS;
                    out_right_next  = FIXED_STEPS;
                    if (action_reg != 24'sd0)
                    begin
                        if ((!action_reg[23]) != mirrored)
                        begin
                            out_right_next = big;
                        end
                        else
                        begin
                            out_left_next = big;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            samp_reg    <= 3'd0;
            chan_reg    <= 2'd0;
            last_reg    <= COLOR_BLACK;
            prev_reg    <= 4'sd0;
            int_reg     <= 6'sd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            samp_reg    <= samp_next;
            chan_reg    <= chan_next;
            last_reg    <= last_next;
            prev_reg    <= prev_next;
            int_reg     <= int_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        red_reg        <= red_next;
        green_reg      <= green_next;
        blue_reg       <= blue_next;
        clear_reg      <= clear_next;
        heading_reg    <= heading_next;
        best_idx_reg   <= best_idx_next;
        best_dist_reg  <= best_dist_next;
        color_reg      <= color_next;
        err_reg        <= err_next;
        dprev_reg      <= dprev_next;
        neg_reg        <= neg_next;
        mag_reg        <= mag_next;
        action_reg     <= action_next;
        out_color_reg  <= out_color_next;
        out_action_reg <= out_action_next;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
    end

`ifndef NO_ASSERTIONS
    // an accepted beat keeps the input side closed while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a beat is in progress");

    // the anti-windup window keeps the integral in a narrow band
    assert property (@(posedge clk) disable iff (!rst_n)
        (int_reg >= -6'sd15) && (int_reg <= 6'sd13))
    else $error("error integral left its window");

    // red never becomes the last track color
    assert property (@(posedge clk) disable iff (!rst_n)
        (last_reg != COLOR_RED) && (last_reg != 3'd6))
    else $error("invalid last track color");

    // the nearest sample index stays inside the sample table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRACK) |-> (best_idx_reg <= LAST_SAMPLE))
    else $error("nearest sample index out of range");

    // one wheel always gets the fixed count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (out_left_reg == FIXED_STEPS || out_right_reg == FIXED_STEPS))
    else $error("neither wheel carries the fixed step count");
`endif

endmodule

@@ sim/tb_line_follow_color_pid.sv @@
// tb_line_follow_color_pid: self-checking testbench for the color classifier and PID steering block
`timescale 1ns / 1ps

module tb_line_follow_color_pid;

    import lfcp_pkg::*;

    // one color sensor beat, first field in the lowest bits
    typedef struct packed {
        logic [1:0]  heading;
        logic [15:0] clear;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } sensor_t;

    // one steering result beat, first field in the lowest bits
    typedef struct packed {
        logic [15:0]        right;
        logic [15:0]        left;
        logic signed [23:0] action;
        logic [2:0]         color;
    } steering_t;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_PER_PHASE = 264;

    // fixed color samples: red, green, blue and the class each one stands for
    localparam int CENTROID_R [5] = '{27, 0, 48, 112, 255};
    localparam int CENTROID_G [5] = '{46, 0, 104, 11, 255};
    localparam int CENTROID_B [5] = '{100, 0, 70, 18, 255};
    localparam logic [2:0] CENTROID_CLASS [5] =
        '{COLOR_BLUE, COLOR_BLACK, COLOR_GREEN, COLOR_RED, COLOR_WHITE};

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_GAIN_P;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = 48'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    // steering state as the block should hold it
    int gain_p;
    int gain_i;
    int gain_d;
    int track_last;
    int prev_err;
    int err_sum;

    sensor_t   sensor_queue [$];
    steering_t steering_due [$];
    sensor_t   bus_item;
    bit        beat_busy = 1'b0;
    int        fail_count = 0;
    int        idle_cycles = 0;

    int tx_gap = 0;
    int tx_calm_left = 0;
    bit tx_calm = 1'b0;
    int rx_stall = 0;
    int rx_calm_left = 0;
    bit rx_calm = 1'b0;

    line_follow_color_pid dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // classify one beat, advance the track, integral and derivative state,
    // and form the action and wheel step counts
    function automatic steering_t compute_steering(sensor_t s);
        steering_t res;
        logic [2:0] color;
        int         best_d;
        int         best_i;
        int         sq_dist;
        int         dr;
        int         dg;
        int         db;
        int         reading;
        int         err;
        int         window;
        longint     act;
        longint     mag;
        bit         mirrored;
        color = COLOR_WHITE;
        best_d = 0;
        best_i = 0;
        err = 0;
        if (s.clear > WHITE_LIMIT)
        begin
            color = COLOR_WHITE;
        end
        else
        begin
            // nearest sample, first one wins a tie
            for (int i = 0; i < 5; i++)
            begin
                dr = int'(s.red) - CENTROID_R[i];
                dg = int'(s.green) - CENTROID_G[i];
                db = int'(s.blue) - CENTROID_B[i];
                sq_dist = dr * dr + dg * dg + db * db;
                if (i == 0 || sq_dist < best_d)
                begin
                    best_d = sq_dist;
                    best_i = i;
                end
            end
            color = CENTROID_CLASS[best_i];
        end

        // white is a border on the side of the last track color
        reading = int'(color);
        if (color == COLOR_WHITE && track_last > int'(COLOR_BLACK))
            reading = int'(READ_GREEN_EDGE);
        else if (color == COLOR_WHITE && track_last < int'(COLOR_BLACK))
            reading = int'(READ_BLUE_EDGE);
        if (reading != int'(COLOR_RED))
        begin
            err = int'(COLOR_BLACK) - reading;
            track_last = reading;
        end

        // anti-windup: integrate only inside the window
        window = 2 * err_sum + err;
        if (window <= INT_WINDOW && window >= -INT_WINDOW)
            err_sum += err;

        act = longint'(gain_p) * err + (longint'(gain_i) * err_sum) / 3
            + longint'(gain_d) * (prev_err - err);
        prev_err = err;
        if (act > 64'sd8388607)
            act = 64'sd8388607;
        if (act < -64'sd8388608)
            act = -64'sd8388608;

        mag = (act < 0) ? -act : act;
        mag = (mag * 30) >>> 8;
        if (mag > 65535)
            mag = 65535;
        mirrored = (s.heading == 2'd1 || s.heading == 2'd2);
        res.color = color;
        res.action = act[23:0];
        res.left = FIXED_STEPS;
        res.right = FIXED_STEPS;
        if (act != 0)
        begin
            if ((act > 0) != mirrored)
                res.right = mag[15:0];
            else
                res.left = mag[15:0];
        end
        return res;
    endfunction

    // idle length: mostly short, a few long
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        else if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // level near a sample channel, clamped to 0..255
    function automatic logic [7:0] jitter(int base);
        int v;
        v = base + $urandom_range(0, 40) - 20;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    task automatic add_item(int r, int g, int b, int clr, int hd);
        sensor_t s;
        s.red = 8'(r);
        s.green = 8'(g);
        s.blue = 8'(b);
        s.clear = 16'(clr);
        s.heading = 2'(hd);
        sensor_queue = {sensor_queue, s};
    endtask

    // a run of beats of one kind, so the track and integral states build up
    task automatic add_random(int count);
        int added;
        int kind;
        int run;
        int k;
        added = 0;
        while (added < count)
        begin
            kind = $urandom_range(0, 9);
            run = $urandom_range(1, 8);
            k = $urandom_range(0, 4);
            for (int n = 0; n < run && added < count; n++)
            begin
                if (kind <= 4)
                    add_item(jitter(CENTROID_R[k]), jitter(CENTROID_G[k]),
                             jitter(CENTROID_B[k]), $urandom_range(0, 1200),
                             $urandom_range(0, 3));
                else if (kind <= 6)
                    add_item($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(1201, 65535),
                             $urandom_range(0, 3));
                else if (kind == 7)
                    add_item($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(1199, 1202),
                             $urandom_range(0, 3));
                else
                    add_item($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255),
                             ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1200)
                                                         : $urandom_range(0, 65535),
                             $urandom_range(0, 3));
                added++;
            end
        end
    endtask

    task automatic write_gain(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_GAIN_P: gain_p = int'($signed(val));
            REG_GAIN_I: gain_i = int'($signed(val));
            REG_GAIN_D: gain_d = int'($signed(val));
            default:    gain_p = gain_p;
        endcase
    endtask

    task automatic set_gains(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd);
        write_gain(REG_GAIN_P, gp);
        write_gain(REG_GAIN_I, gi);
        write_gain(REG_GAIN_D, gd);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (sensor_queue.size() != 0 || beat_busy || steering_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // main sequence: reset, directed beats, then random phases over gain settings
    initial
    begin
        gain_p = 256;
        gain_i = 0;
        gain_d = 128;
        track_last = int'(COLOR_BLACK);
        prev_err = 0;
        err_sum = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains: each class, white by clear and by distance, border sides,
        // white after black, red holding the track, a blue and red tie
        add_item(0, 0, 0, 0, 0);
        add_item(27, 46, 100, 1000, 1);
        add_item(0, 0, 0, 1201, 2);
        add_item(48, 104, 70, 500, 3);
        add_item(255, 255, 255, 1200, 0);
        add_item(112, 11, 18, 0, 1);
        add_item(255, 255, 255, 65535, 3);
        add_item(0, 0, 0, 0, 2);
        add_item(255, 255, 255, 65535, 3);
        add_item(66, 20, 59, 1200, 0);
        add_item(0, 0, 0, 1201, 1);
        add_item(112, 11, 18, 65535, 2);
        add_item(255, 0, 255, 0, 3);
        add_item(0, 255, 0, 1199, 0);
        for (int i = 0; i < 6; i++)
            add_item(27, 46, 100, 0, i % 4);
        for (int i = 0; i < 5; i++)
            add_item(0, 0, 0, 4000, i % 4);
        add_random(RANDOM_PER_PHASE);
        drain();

        set_gains(16'h7FFF, 16'h8000, 16'h7FFF);
        add_random(RANDOM_PER_PHASE);
        drain();

        set_gains(16'h8000, 16'h7FFF, 16'h8000);
        add_random(RANDOM_PER_PHASE);
        drain();

        set_gains(16'h0000, 16'h0000, 16'h0000);
        add_random(RANDOM_PER_PHASE);
        drain();

        set_gains(16'd256, 16'd768, 16'hFF80);
        add_random(RANDOM_PER_PHASE);
        drain();

        for (int ph = 0; ph < 2; ph++)
        begin
            set_gains(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)));
            add_random(RANDOM_PER_PHASE);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // sensor beat driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // stretches with no idling on this side
            if (tx_calm_left == 0)
            begin
                tx_calm_left = $urandom_range(50, 400);
                tx_calm = ($urandom_range(0, 3) == 0);
            end
            else
            begin
                tx_calm_left--;
            end

            if (s_tvalid && s_tready)
            begin
                steering_due = {steering_due, compute_steering(bus_item)};
                beat_busy = 1'b0;
                tx_gap = tx_calm ? 0 : idle_len();
            end

            if (!beat_busy)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (sensor_queue.size() > 0)
                begin
                    bus_item = sensor_queue.pop_front();
                    s_tdata <= {6'd0, bus_item};
                    s_tvalid <= 1'b1;
                    beat_busy = 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result beat monitor and back-pressure
    always @(posedge clk)
    begin
        steering_t got;
        steering_t want;
        if (rst_n)
        begin
            if (rx_calm_left == 0)
            begin
                rx_calm_left = $urandom_range(50, 400);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            else
            begin
                rx_calm_left--;
            end

            if (m_tvalid && m_tready)
            begin
                got = steering_t'(m_tdata[58:0]);
                if (steering_due.size() == 0)
                begin
                    $display("%0t ns: result beat with none expected, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = steering_due.pop_front();
                    check_field("color_class", int'(want.color), int'(got.color));
                    check_field("control_action", int'(want.action), int'(got.action));
                    check_field("left_steps", int'(want.left), int'(got.left));
                    check_field("right_steps", int'(want.right), int'(got.right));
                end
            end

            if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 4) == 0)
                    rx_stall = idle_len();
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
